>>> sv/aek_pkg.sv
package aek_pkg;

   // Key and position geometry
   localparam int unsigned KeyCount = 8;
   localparam int unsigned KeyWidth = 32;
   localparam int unsigned PosWidth = 3;

   // Packed stream widths (key_0 / order_0 in the lowest bits)
   localparam int unsigned ReqDataWidth = KeyCount * KeyWidth;
   localparam int unsigned RspDataWidth = KeyCount * PosWidth;

   typedef logic signed [KeyWidth-1:0] key_type;
   typedef logic [PosWidth-1:0]        pos_type;

   typedef key_type [KeyCount-1:0]     key_array_type;
   typedef pos_type [KeyCount-1:0]     order_array_type;

endpackage

>>> sv/aek_rank.sv
module aek_rank (
   input  aek_pkg::key_array_type   keys,
   output aek_pkg::order_array_type order
);
   import aek_pkg::*;

   pos_type rank [KeyCount];

   // Stable rank of each key: count keys below it, ties broken by position
   always_comb begin
      for (int i = 0; i < KeyCount; i++) begin
         rank[i] = '0;
         for (int j = 0; j < KeyCount; j++) begin
            if (j != i) begin
               if ((keys[j] < keys[i]) || ((keys[j] == keys[i]) && (j < i))) begin
                  rank[i] = rank[i] + pos_type'(1);
               end
            end
         end
      end
   end

   // Scatter positions to their ranks; ranks always form a permutation
   always_comb begin
      for (int k = 0; k < KeyCount; k++) begin
         order[k] = '0;
         for (int i = 0; i < KeyCount; i++) begin
            if (rank[i] == pos_type'(k)) begin
               order[k] = order[k] | pos_type'(i);
            end
         end
      end
   end

endmodule

>>> sv/argsort_eight_keys_core.sv
// Stable ascending argsort of eight signed Q16.16 keys.
//
// Request channel (req_*): one transaction carries key_0..key_7 packed in
// req_tdata, key_0 in the lowest 32 bits. Keys compare as signed 32-bit
// integers.
// Response channel (rsp_*): one transaction per request, order_0..order_7
// packed in rsp_tdata, 3 bits each, order_0 (position of the smallest key)
// lowest. Equal keys keep input order, lower position first.
//
// A request passes the input register, then the pairwise compare, rank count
// and scatter settle into the response register, which drives rsp_tvalid. A
// request can be taken every cycle while the receiver does not stall; the
// rate is set by the single compare stage between the two registers.
//
// Reset (synchronous, active high) empties both registers; no response is
// pending afterwards. When the receiver stalls, the response register holds
// its transaction and the input register still takes one more request;
// req_tready drops only while both are full and rsp_tready is low.
module argsort_eight_keys_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // key_0 [31:0], key_1 [63:32], ... key_7 [255:224]
   input  logic [aek_pkg::ReqDataWidth-1:0]     req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // order_0 [2:0], order_1 [5:3], ... order_7 [23:21]
   output logic [aek_pkg::RspDataWidth-1:0]     rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready
);
   import aek_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   key_array_type   keys_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   order_array_type order_ff;
   order_array_type order_calc;
   logic            advance;
   logic            req_accept;

   // Handshake: response register advances when the input register is full and it is empty or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         keys_ff <= key_array_type'(req_tdata);
      end
   end

   aek_rank u_rank (
      .keys  (keys_ff),
      .order (order_calc)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (advance) begin
         order_ff <= order_calc;
      end
   end

   assign rsp_tdata  = RspDataWidth'(order_ff);
   assign rsp_tvalid = out_valid_ff;

endmodule

>>> sv/aek_checker.sv
module aek_checker (
   input logic                             clock,
   input logic                             reset,
   input logic [aek_pkg::ReqDataWidth-1:0] req_tdata,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [aek_pkg::RspDataWidth-1:0] rsp_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready
);
   import aek_pkg::*;

   logic [KeyCount-1:0] pos_seen;
   logic                req_unused;

   // Which positions appear in the response
   always_comb begin
      pos_seen = '0;
      for (int k = 0; k < KeyCount; k++) begin
         pos_seen[rsp_tdata[k*PosWidth +: PosWidth]] = 1'b1;
      end
   end

   assign req_unused = ^req_tdata;

   // A stalled response keeps its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Every response is a permutation of the eight positions
   a_rsp_perm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pos_seen == {KeyCount{1'b1}}) || (req_unused && 1'b0))
      else $error("response is not a permutation");

   // Reset leaves no response pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response pending after reset");

   // A fresh response follows a request that was accepted and did not stall in the input register
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without matching request");

endmodule

bind argsort_eight_keys_core aek_checker u_aek_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tdata  (req_tdata),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
